>>> hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Depends on nothing; the datapath, controller and top use it by scoped names.
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;

    // Operation codes of a request beat
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Status codes of a response beat
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Data returned by a dequeue from an empty queue
    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    // Read address select for the entry store
    typedef enum logic [1:0] {
        RD_TAIL_M1,
        RD_K_M2,
        RD_HEAD
    } rd_sel_t;

    // Kind of result staged for the response register
    typedef enum logic [1:0] {
        RES_ENQ_OK,
        RES_ENQ_FULL,
        RES_DEQ_OK,
        RES_DEQ_EMPTY
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      shift;
        logic      put;
        logic      deq;
        logic      res_load;
        res_kind_t res_kind;
        logic      rsp_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic greater;
        logic more_below;
        logic rsp_free;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: entry store, indices, compare,
// staged result and response register. Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire spq_pkg::req_t req,
    input  wire spq_pkg::cmd_t cmd,
    output spq_pkg::stat_t     stat,
    output spq_pkg::rsp_t      rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_stall
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);

    logic signed [spq_pkg::DATA_W-1:0] val_reg;
    logic [IW-1:0]                     head_reg;
    logic [IW-1:0]                     tail_reg;
    logic [IW-1:0]                     k_reg;
    logic [spq_pkg::DATA_W-1:0]        res_data_reg;
    logic [1:0]                        res_status_reg;
    spq_pkg::rsp_t                     rsp_reg;
    logic                              rsp_valid_reg;

    logic [IW-1:0]              tail_m1;
    logic [IW-1:0]              k_m2;
    logic [IW-1:0]              head_p1;
    logic [IW-1:0]              rd_index;
    logic                       wr_en;
    logic [spq_pkg::DATA_W-1:0] wr_data;
    logic [spq_pkg::DATA_W-1:0] rd_data;
    logic                       q_empty;
    logic                       q_full;

    assign tail_m1 = tail_reg - IW'(1);
    assign k_m2    = k_reg - IW'(2);
    assign head_p1 = head_reg + IW'(1);

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            spq_pkg::RD_TAIL_M1: rd_index = tail_m1;
            spq_pkg::RD_K_M2:    rd_index = k_m2;
            spq_pkg::RD_HEAD:    rd_index = head_reg;
            default:             rd_index = head_reg;
        endcase
    end

    // Shift moves the entry just read up one slot; put drops the new value in
    assign wr_en   = cmd.shift | cmd.put;
    assign wr_data = cmd.shift ? rd_data : val_reg;

    spq_ram #(
        .WIDTH (spq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (k_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_index[AW-1:0]),
        .rd_data (rd_data)
    );

    assign q_empty = (head_reg == '0) && (tail_reg == '0);
    assign q_full  = (tail_reg == IW'(DEPTH));

    // Status back to the controller
    always_comb
    begin
        stat.full       = q_full;
        stat.empty      = q_empty;
        stat.greater    = val_reg > $signed(rd_data);
        stat.more_below = k_reg > head_p1;
        stat.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

    // Indices and insert cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                k_reg <= tail_reg;
            end
            else if (cmd.shift)
            begin
                k_reg <= k_reg - IW'(1);
            end
            if (cmd.put)
            begin
                tail_reg <= tail_reg + IW'(1);
            end
            if (cmd.deq)
            begin
                if (head_p1 >= tail_reg)
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                else
                begin
                    head_reg <= head_p1;
                end
            end
        end
    end

    // Item value and staged result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            val_reg <= req.value;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                spq_pkg::RES_ENQ_OK:
                begin
                    res_data_reg   <= '0;
                    res_status_reg <= spq_pkg::STATUS_OK;
                end
                spq_pkg::RES_ENQ_FULL:
                begin
                    res_data_reg   <= '0;
                    res_status_reg <= spq_pkg::STATUS_FULL;
                end
                spq_pkg::RES_DEQ_OK:
                begin
                    res_data_reg   <= rd_data;
                    res_status_reg <= spq_pkg::STATUS_OK;
                end
                default:
                begin
                    res_data_reg   <= spq_pkg::EMPTY_DATA;
                    res_status_reg <= spq_pkg::STATUS_EMPTY;
                end
            endcase
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg.data     <= $signed(res_data_reg);
            rsp_reg.status   <= res_status_reg;
            rsp_reg.is_empty <= q_empty;
            rsp_reg.is_full  <= q_full;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Live window stays ordered: head below tail, or both at zero
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg < tail_reg) || q_empty)
        else $error("head/tail window broken");

    // A put grows the queue by exactly one entry
    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> (tail_reg == $past(tail_reg) + IW'(1)))
        else $error("tail did not advance on put");

    // A shift only happens above the head
    a_shift_above_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (k_reg > head_reg))
        else $error("shift at or below head");

endmodule

`default_nettype wire

>>> hw/rtl/spq_controller.sv
// Controller of the sorted priority queue: sequences insert, remove and
// response handoff. Depends on spq_pkg.
`default_nettype none

module spq_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic           req_op,
    output logic                req_stall,
    input  wire spq_pkg::stat_t stat,
    output spq_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_DEQ,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = spq_pkg::RD_HEAD;
        cmd.res_kind = spq_pkg::RES_ENQ_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (req_op == spq_pkg::OP_ENQUEUE)
                    begin
                        if (stat.full)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = spq_pkg::RES_ENQ_FULL;
                            state_next   = S_DONE;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = spq_pkg::RD_TAIL_M1;
                            state_next = S_CMP;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = spq_pkg::RES_DEQ_EMPTY;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = spq_pkg::RD_HEAD;
                            state_next = S_DEQ;
                        end
                    end
                end
            end
            // Walk down from the tail, moving smaller entries up one slot
            S_CMP:
            begin
                if (stat.greater)
                begin
                    cmd.shift = 1'b1;
                    if (stat.more_below)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = spq_pkg::RD_K_M2;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.put      = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = spq_pkg::RES_ENQ_OK;
                state_next   = S_DONE;
            end
            S_DEQ:
            begin
                cmd.deq      = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = spq_pkg::RES_DEQ_OK;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Dropped or empty requests go straight to the response handoff
    a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid &&
         ((req_op == spq_pkg::OP_ENQUEUE && stat.full) ||
          (req_op == spq_pkg::OP_DEQUEUE && stat.empty)))
        |=> (state_reg == S_DONE))
        else $error("dropped request did not go to response");

    // Store is never written while a response is being handed off
    a_no_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !(cmd.shift || cmd.put || cmd.deq))
        else $error("store update during response handoff");

    // Handoff waits while the response register is still held
    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !stat.rsp_free) |=> (state_reg == S_DONE))
        else $error("response handoff left while register busy");

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// Max-priority queue kept as a descending sorted array in a RAM.
// A dropped enqueue or an empty dequeue goes straight to the response
// handoff; a dequeue first reads the head, and an enqueue first walks down
// from the tail, at most DEPTH-1 compares, one RAM read per compare.
// The next request is taken the cycle after the response is registered.
// Reset clears head, tail and control at once; the store holds no reset.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire spq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output spq_pkg::rsp_t      rsp
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

`default_nettype wire
